// File: rtl/acls_pkg.sv
// Shared types and constants of the ADC conversion list sequencer.
`default_nettype none

package acls_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int TAG_BITS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int CHAN_BITS       = 3;

    typedef enum logic {
        FUNC_REQUEST = 1'b0,
        FUNC_DONE    = 1'b1
    } t_func;

    typedef struct packed {
        logic deliver_valid;
        logic start_conversion;
        logic converter_on;
        logic request_accepted;
    } t_flags;

endpackage

`default_nettype wire

// File: rtl/acls_if.sv
// Channel interfaces for request and result transactions.
`default_nettype none

interface acls_req_if
    import acls_pkg::*;
#(
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    t_func                  func;
    logic [CHAN_BITS-1:0]   channel;
    logic [TAG_BITS-1:0]    dest_tag;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, func, channel, dest_tag, sample, input ready);
    modport sink   (input valid, func, channel, dest_tag, sample, output ready);
endinterface

interface acls_res_if
    import acls_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    localparam int ACT_W = $clog2(SLOTS + 1);

    logic                   valid;
    logic                   ready;
    logic                   deliver_valid;
    logic [TAG_BITS-1:0]    deliver_tag;
    logic [SAMPLE_BITS-1:0] deliver_value;
    logic                   start_conversion;
    logic [CHAN_BITS-1:0]   mux_select;
    logic                   converter_on;
    logic                   request_accepted;
    logic [ACT_W-1:0]       active_slot;

    modport source (
        output valid, deliver_valid, deliver_tag, deliver_value, start_conversion,
               mux_select, converter_on, request_accepted, active_slot,
        input  ready
    );
    modport sink (
        input  valid, deliver_valid, deliver_tag, deliver_value, start_conversion,
               mux_select, converter_on, request_accepted, active_slot,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/adc_conversion_list_sequencer_unit.sv
// Top level of the ADC conversion list sequencer.
// Each accepted transaction, a channel request or a conversion-done sample, yields
// exactly one result transaction. A transaction is captured in an input register,
// the slot list is updated in one pass of logic, and the result is captured in a
// result register that holds it until it is taken. One transaction is taken every
// cycle as long as results are taken. The list holds SLOTS entries; a request while
// idle restarts the list at slot zero and launches its conversion, and the active
// slot reads SLOTS while idle.
`default_nettype none

module adc_conversion_list_sequencer_unit
    import acls_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    acls_req_if.sink    i_req,
    acls_res_if.source  o_res
);

    localparam int ACT_W = $clog2(SLOTS + 1);

    logic                   w_in_valid;
    t_func                  w_func;
    logic [CHAN_BITS-1:0]   w_channel;
    logic [TAG_BITS-1:0]    w_tag;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic                   w_out_free;
    logic                   w_advance;
    t_flags                 w_flags;
    logic [TAG_BITS-1:0]    w_deliver_tag;
    logic [SAMPLE_BITS-1:0] w_deliver_value;
    logic [CHAN_BITS-1:0]   w_mux_select;
    logic [ACT_W-1:0]       w_active_slot;

    assign w_advance = w_in_valid && w_out_free;

    acls_in_reg #(
        .TAG_BITS    (TAG_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_func    (w_func),
        .o_channel (w_channel),
        .o_tag     (w_tag),
        .o_sample  (w_sample)
    );

    acls_list #(
        .SLOTS       (SLOTS),
        .TAG_BITS    (TAG_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACT_W       (ACT_W)
    ) u_list (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_advance),
        .i_func          (w_func),
        .i_channel       (w_channel),
        .i_tag           (w_tag),
        .i_sample        (w_sample),
        .o_flags         (w_flags),
        .o_deliver_tag   (w_deliver_tag),
        .o_deliver_value (w_deliver_value),
        .o_mux_select    (w_mux_select),
        .o_active_slot   (w_active_slot)
    );

    acls_out_reg #(
        .SLOTS       (SLOTS),
        .TAG_BITS    (TAG_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACT_W       (ACT_W)
    ) u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_advance),
        .i_flags         (w_flags),
        .i_deliver_tag   (w_deliver_tag),
        .i_deliver_value (w_deliver_value),
        .i_mux_select    (w_mux_select),
        .i_active_slot   (w_active_slot),
        .o_free          (w_out_free),
        .o_res           (o_res)
    );

endmodule

`default_nettype wire

// File: rtl/acls_in_reg.sv
// Input register that captures one request or conversion-done transaction.
`default_nettype none

module acls_in_reg
    import acls_pkg::*;
#(
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    acls_req_if.sink               i_req,
    input  wire                    i_advance,
    output logic                   o_valid,
    output t_func                  o_func,
    output logic [CHAN_BITS-1:0]   o_channel,
    output logic [TAG_BITS-1:0]    o_tag,
    output logic [SAMPLE_BITS-1:0] o_sample
);

    logic                   r_valid;
    t_func                  r_func;
    logic [CHAN_BITS-1:0]   r_channel;
    logic [TAG_BITS-1:0]    r_tag;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   w_ready;

    assign w_ready     = !r_valid || i_advance;
    assign i_req.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_req.valid) begin
            r_func    <= i_req.func;
            r_channel <= i_req.channel;
            r_tag     <= i_req.dest_tag;
            r_sample  <= i_req.sample;
        end
    end

    assign o_valid   = r_valid;
    assign o_func    = r_func;
    assign o_channel = r_channel;
    assign o_tag     = r_tag;
    assign o_sample  = r_sample;

endmodule

`default_nettype wire

// File: rtl/acls_list.sv
// Slot list state and the single-pass update for one transaction.
`default_nettype none

module acls_list
    import acls_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int ACT_W       = $clog2(SLOTS + 1)
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_fire,
    input  t_func                  i_func,
    input  wire [CHAN_BITS-1:0]    i_channel,
    input  wire [TAG_BITS-1:0]     i_tag,
    input  wire [SAMPLE_BITS-1:0]  i_sample,
    output t_flags                 o_flags,
    output logic [TAG_BITS-1:0]    o_deliver_tag,
    output logic [SAMPLE_BITS-1:0] o_deliver_value,
    output logic [CHAN_BITS-1:0]   o_mux_select,
    output logic [ACT_W-1:0]       o_active_slot
);

    localparam int              SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [ACT_W-1:0] IDLE   = ACT_W'(SLOTS);

    logic [CHAN_BITS-1:0] r_slot_input  [SLOTS];
    logic [TAG_BITS-1:0]  r_slot_target [SLOTS];
    logic [ACT_W-1:0]     r_fill;
    logic [ACT_W-1:0]     r_active;
    logic [ACT_W-1:0]     n_fill;
    logic [ACT_W-1:0]     n_active;

    logic                 w_busy;
    logic [ACT_W-1:0]     w_base;
    logic [ACT_W-1:0]     w_next;
    logic                 w_wr_en;

    assign w_busy = (r_active != IDLE);
    assign w_base = w_busy ? r_fill : '0;
    assign w_next = r_active + ACT_W'(1);

    always_comb begin
        o_flags         = '0;
        o_deliver_tag   = '0;
        o_deliver_value = '0;
        o_mux_select    = '0;
        n_fill          = r_fill;
        n_active        = r_active;
        w_wr_en         = 1'b0;
        case (i_func)
            FUNC_REQUEST: begin
                if (w_base < ACT_W'(SLOTS)) begin
                    w_wr_en                  = 1'b1;
                    n_fill                   = w_base + ACT_W'(1);
                    o_flags.request_accepted = 1'b1;
                    if (!w_busy) begin
                        n_active                 = '0;
                        o_flags.start_conversion = 1'b1;
                        o_mux_select             = i_channel;
                    end
                end
            end
            FUNC_DONE: begin
                if (w_busy) begin
                    o_flags.deliver_valid = 1'b1;
                    o_deliver_tag         = r_slot_target[r_active[SLOT_AW-1:0]];
                    o_deliver_value       = i_sample;
                    if (w_next < r_fill) begin
                        n_active                 = w_next;
                        o_flags.start_conversion = 1'b1;
                        o_mux_select             = r_slot_input[w_next[SLOT_AW-1:0]];
                    end else begin
                        n_active = IDLE;
                    end
                end
            end
            default: begin
                n_active = r_active;
            end
        endcase
        o_flags.converter_on = (n_active != IDLE);
        o_active_slot        = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_active <= IDLE;
        end else if (i_fire) begin
            r_fill   <= n_fill;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && w_wr_en) begin
            r_slot_input[w_base[SLOT_AW-1:0]]  <= i_channel;
            r_slot_target[w_base[SLOT_AW-1:0]] <= i_tag;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= ACT_W'(SLOTS))
        else $error("Fill index ran past the end of the list.");

    a_active_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> (r_active < r_fill))
        else $error("Active slot lies beyond the filled part of the list.");

    a_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_func == FUNC_REQUEST && !w_busy) |=>
            (r_active == '0 && r_fill == ACT_W'(1)))
        else $error("A request while idle did not restart the list at slot zero.");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_func == FUNC_DONE && !w_busy) |=>
            (r_active == IDLE && $stable(r_fill)))
        else $error("A conversion-done transaction while idle changed the list.");
`endif

endmodule

`default_nettype wire

// File: rtl/acls_out_reg.sv
// Result register that holds one result transaction until it is taken.
`default_nettype none

module acls_out_reg
    import acls_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int ACT_W       = $clog2(SLOTS + 1)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  t_flags                i_flags,
    input  wire [TAG_BITS-1:0]    i_deliver_tag,
    input  wire [SAMPLE_BITS-1:0] i_deliver_value,
    input  wire [CHAN_BITS-1:0]   i_mux_select,
    input  wire [ACT_W-1:0]       i_active_slot,
    output logic                  o_free,
    acls_res_if.source            o_res
);

    logic                   r_valid;
    t_flags                 r_flags;
    logic [TAG_BITS-1:0]    r_deliver_tag;
    logic [SAMPLE_BITS-1:0] r_deliver_value;
    logic [CHAN_BITS-1:0]   r_mux_select;
    logic [ACT_W-1:0]       r_active_slot;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags         <= i_flags;
            r_deliver_tag   <= i_deliver_tag;
            r_deliver_value <= i_deliver_value;
            r_mux_select    <= i_mux_select;
            r_active_slot   <= i_active_slot;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.deliver_valid    = r_flags.deliver_valid;
    assign o_res.deliver_tag      = r_deliver_tag;
    assign o_res.deliver_value    = r_deliver_value;
    assign o_res.start_conversion = r_flags.start_conversion;
    assign o_res.mux_select       = r_mux_select;
    assign o_res.converter_on     = r_flags.converter_on;
    assign o_res.request_accepted = r_flags.request_accepted;
    assign o_res.active_slot      = r_active_slot;

endmodule

`default_nettype wire

// File: tb/acls_result_checker.sv
// Scoreboard for the ADC conversion list sequencer: predicts each result and compares it.
`timescale 1ns / 1ps

module acls_result_checker
    import acls_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    acls_req_if  i_req_mon,
    acls_res_if  i_res_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_useful_count
);

    localparam int ACT_W = $clog2(SLOTS + 1);

    typedef struct packed {
        logic                   deliver_valid;
        logic [TAG_BITS-1:0]    deliver_tag;
        logic [SAMPLE_BITS-1:0] deliver_value;
        logic                   start_conversion;
        logic [CHAN_BITS-1:0]   mux_select;
        logic                   converter_on;
        logic                   request_accepted;
        logic [ACT_W-1:0]       active_slot;
    } t_scan_result;

    logic [CHAN_BITS-1:0] slot_chan [SLOTS];
    logic [TAG_BITS-1:0]  slot_tag  [SLOTS];
    bit                   slot_full [SLOTS];
    int                   fill_ptr;
    int                   active_ptr;
    bit                   scan_busy;

    t_scan_result scan_results[$];
    int           fail_count;
    int           useful_count;

    task automatic clear_scan_list();
        for (int i = 0; i < SLOTS; i++) begin
            slot_full[i] = 1'b0;
        end
        fill_ptr   = 0;
        active_ptr = SLOTS;
        scan_busy  = 1'b0;
    endtask

    task automatic advance_scan_list(
        input  t_func                  fn,
        input  logic [CHAN_BITS-1:0]   chan,
        input  logic [TAG_BITS-1:0]    tag,
        input  logic [SAMPLE_BITS-1:0] smp,
        output t_scan_result           res
    );
        bit was_idle;
        res = '0;
        if (fn == FUNC_REQUEST) begin
            was_idle = !scan_busy;
            if (was_idle) begin
                fill_ptr = 0;
            end
            if (fill_ptr < SLOTS) begin
                slot_chan[fill_ptr] = chan;
                slot_tag[fill_ptr]  = tag;
                slot_full[fill_ptr] = 1'b1;
                fill_ptr++;
                res.request_accepted = 1'b1;
                if (was_idle) begin
                    scan_busy            = 1'b1;
                    active_ptr           = 0;
                    res.start_conversion = 1'b1;
                    res.mux_select       = chan;
                end
            end
        end else if (scan_busy && active_ptr < SLOTS) begin
            res.deliver_valid     = 1'b1;
            res.deliver_tag       = slot_tag[active_ptr];
            res.deliver_value     = smp;
            slot_full[active_ptr] = 1'b0;
            active_ptr++;
            if (active_ptr < SLOTS && slot_full[active_ptr]) begin
                res.start_conversion = 1'b1;
                res.mux_select       = slot_chan[active_ptr];
            end else begin
                scan_busy  = 1'b0;
                active_ptr = SLOTS;
            end
        end
        res.converter_on = scan_busy;
        res.active_slot  = scan_busy ? ACT_W'(active_ptr) : ACT_W'(SLOTS);
    endtask

    task automatic check_field(input string fld, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", fld, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count   = 0;
        useful_count = 0;
        clear_scan_list();
    end

    always @(posedge i_clk) begin
        t_scan_result want;
        t_scan_result pred;
        if (!i_rst_n) begin
            clear_scan_list();
            scan_results.delete();
        end else begin
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (scan_results.size() == 0) begin
                    $error("result transaction arrived with no expectation pending");
                    fail_count++;
                end else begin
                    want = scan_results.pop_front();
                    check_field("deliver_valid", want.deliver_valid, i_res_mon.deliver_valid);
                    check_field("deliver_tag", want.deliver_tag, i_res_mon.deliver_tag);
                    check_field("deliver_value", want.deliver_value, i_res_mon.deliver_value);
                    check_field("start_conversion", want.start_conversion,
                                i_res_mon.start_conversion);
                    check_field("mux_select", want.mux_select, i_res_mon.mux_select);
                    check_field("converter_on", want.converter_on, i_res_mon.converter_on);
                    check_field("request_accepted", want.request_accepted,
                                i_res_mon.request_accepted);
                    check_field("active_slot", want.active_slot, i_res_mon.active_slot);
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                if (i_req_mon.func == FUNC_REQUEST || scan_busy) begin
                    useful_count++;
                end
                advance_scan_list(i_req_mon.func, i_req_mon.channel, i_req_mon.dest_tag,
                                  i_req_mon.sample, pred);
                scan_results.push_back(pred);
            end
        end
        o_fail_count   <= fail_count;
        o_pending      <= scan_results.size();
        o_useful_count <= useful_count;
    end

endmodule

// File: tb/adc_conversion_list_sequencer_unit_test.sv
// Top of the testbench for the ADC conversion list sequencer: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module adc_conversion_list_sequencer_unit_test;
    import acls_pkg::*;

    localparam int TARGET_ITEMS = 1350;
    localparam int CALM_ITEMS   = 1200;
    localparam int HOLD_ITEMS   = 300;
    localparam int HOLD_CYCLES  = 150;

    logic clk;
    logic rst_n;
    bit   calm;
    bit   long_hold_done;
    int   fail_count;
    int   pending;
    int   useful_count;

    acls_req_if req_ch ();
    acls_res_if res_ch ();

    adc_conversion_list_sequencer_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    acls_result_checker checker_u (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_mon      (req_ch),
        .i_res_mon      (res_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_useful_count (useful_count)
    );

    initial begin
        clk = 1'b0;
        forever begin
            #5 clk = ~clk;
        end
    end

    initial begin
        #2_000_000;
        $display("adc_conversion_list_sequencer_unit test failed");
        $finish;
    end

    task automatic send_item(
        input t_func       fn,
        input logic [2:0]  chan,
        input logic [7:0]  tag,
        input logic [9:0]  smp
    );
        if (!calm && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= fn;
        req_ch.channel  <= chan;
        req_ch.dest_tag <= tag;
        req_ch.sample   <= smp;
        @(posedge clk);
        while (!req_ch.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_random(input t_func fn);
        send_item(fn, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  10'($urandom_range(0, 1023)));
    endtask

    initial begin
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (!calm && !long_hold_done && useful_count >= HOLD_ITEMS) begin
                long_hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(negedge clk);
            end
        end
    end

    initial begin
        int n;
        int mode;
        calm            = 1'b0;
        long_hold_done  = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.func     = FUNC_REQUEST;
        req_ch.channel  = '0;
        req_ch.dest_tag = '0;
        req_ch.sample   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: ignored completion, full list, drained list, stop at an empty slot.
        send_item(FUNC_DONE, 3'd0, 8'd0, 10'd1023);
        send_item(FUNC_REQUEST, 3'd0, 8'd0, 10'd0);
        send_item(FUNC_REQUEST, 3'd7, 8'd255, 10'd1023);
        for (int c = 1; c <= 6; c++) begin
            send_item(FUNC_REQUEST, 3'(c), 8'($urandom_range(0, 255)), 10'd0);
        end
        send_item(FUNC_REQUEST, 3'd5, 8'hAA, 10'd0);
        send_item(FUNC_DONE, 3'd0, 8'd0, 10'd0);
        send_item(FUNC_DONE, 3'd7, 8'd255, 10'd1023);
        for (int k = 0; k < 6; k++) begin
            send_random(FUNC_DONE);
        end
        send_item(FUNC_DONE, 3'd0, 8'd0, 10'h155);
        send_item(FUNC_REQUEST, 3'd3, 8'h55, 10'd0);
        send_item(FUNC_DONE, 3'd0, 8'd0, 10'h2AA);
        send_item(FUNC_REQUEST, 3'd6, 8'd1, 10'd0);
        send_item(FUNC_REQUEST, 3'd2, 8'd254, 10'd0);
        send_random(FUNC_DONE);
        send_random(FUNC_DONE);

        // Random part: mostly fill-then-drain scans, some interleaving, a little noise.
        while (useful_count < TARGET_ITEMS) begin
            if (useful_count >= CALM_ITEMS) begin
                calm = 1'b1;
            end
            mode = $urandom_range(0, 9);
            if (mode < 6) begin
                n = $urandom_range(1, 10);
                repeat (n) send_random(FUNC_REQUEST);
                repeat ($urandom_range(n, n + 2)) send_random(FUNC_DONE);
            end else if (mode < 9) begin
                repeat ($urandom_range(4, 16)) begin
                    send_random($urandom_range(0, 1) ? FUNC_DONE : FUNC_REQUEST);
                end
            end else begin
                send_random(t_func'($urandom_range(0, 1)));
            end
        end
        req_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("adc_conversion_list_sequencer_unit test passed");
        end else begin
            $display("adc_conversion_list_sequencer_unit test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/acls_pkg.sv
rtl/acls_if.sv
rtl/acls_in_reg.sv
rtl/acls_list.sv
rtl/acls_out_reg.sv
rtl/adc_conversion_list_sequencer_unit.sv
tb/acls_result_checker.sv
tb/adc_conversion_list_sequencer_unit_test.sv
